// ===== design/gpio_controller_edge_irq_unit_assert.svh =====
// Assertion macros for the GPIO edge-interrupt controller.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef GPIO_CONTROLLER_EDGE_IRQ_UNIT_ASSERT_SVH
`define GPIO_CONTROLLER_EDGE_IRQ_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted
`define GPIOEI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs during reset
`define GPIOEI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GPIOEI_ASSERT(label, clk, rst_n, prop, msg)
`define GPIOEI_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== design/gpioei_pkg.sv =====
// Shared constants for the GPIO edge-interrupt controller: field widths,
// operation codes, register word offsets, the PWM window and status bits. No dependencies.
`default_nettype none

package gpioei_pkg;

    // Field widths
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 32;
    localparam int PIN_W   = 5;
    localparam int OP_W    = 2;
    localparam int WORD_W  = ADDR_W - 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_PIN   = 2'd2;

    // Register word offsets (byte offset / 4)
    localparam logic [WORD_W-1:0] W_INPUT    = 14'h0000;
    localparam logic [WORD_W-1:0] W_OE       = 14'h0001;
    localparam logic [WORD_W-1:0] W_IRQ_MASK = 14'h0002;
    localparam logic [WORD_W-1:0] W_PENDING  = 14'h0003;
    localparam logic [WORD_W-1:0] W_OUT      = 14'h0004;
    localparam logic [WORD_W-1:0] W_OUT_SET  = 14'h0005;
    localparam logic [WORD_W-1:0] W_OUT_CLR  = 14'h0006;
    localparam logic [WORD_W-1:0] W_OE_SET   = 14'h0007;
    localparam logic [WORD_W-1:0] W_OE_CLR   = 14'h0008;
    localparam logic [WORD_W-1:0] W_DEBOUNCE = 14'h0009;
    localparam logic [WORD_W-1:0] W_RISE_EN  = 14'h000A;
    localparam logic [WORD_W-1:0] W_FALL_EN  = 14'h000B;
    localparam logic [WORD_W-1:0] W_RISE_PND = 14'h000C;
    localparam logic [WORD_W-1:0] W_FALL_PND = 14'h000D;
    localparam logic [WORD_W-1:0] W_STATUS   = 14'h000F;
    localparam logic [WORD_W-1:0] W_INVERT   = 14'h0010;
    localparam logic [WORD_W-1:0] W_DIVIDER  = 14'h0012;
    localparam logic [WORD_W-1:0] W_PWM_TMR  = 14'h0013;
    localparam logic [WORD_W-1:0] W_PULL_EN  = 14'h0014;
    localparam logic [WORD_W-1:0] W_PULL_SNS = 14'h0015;

    // Per-pin PWM window, byte addresses inclusive
    localparam logic [ADDR_W-1:0] PWM_FIRST   = 16'h0080;
    localparam logic [ADDR_W-1:0] PWM_LAST    = 16'h017F;
    localparam int                PWM_ENTRIES = 32;
    localparam int                PWM_IDX_W   = 5;

    // Status word bits
    localparam logic [DATA_W-1:0] STATUS_RISE = 32'h0000_0001;
    localparam logic [DATA_W-1:0] STATUS_FALL = 32'h0000_0002;

endpackage

`default_nettype wire

// ===== design/gpioei_if.sv =====
// Valid/ready channel interfaces for the GPIO edge-interrupt controller.
// Depends on gpioei_pkg for field widths.
`default_nettype none

interface gpioei_cmd_if;
    import gpioei_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic [PIN_W-1:0]  pin_index;
    logic              pin_level;

    modport source (
        output valid, operation, address, write_data, pin_index, pin_level,
        input  ready
    );
    modport sink (
        input  valid, operation, address, write_data, pin_index, pin_level,
        output ready
    );
endinterface

interface gpioei_rsp_if;
    import gpioei_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq_line;
    logic [DATA_W-1:0] pin_drive;

    modport source (
        output valid, read_data, irq_line, pin_drive,
        input  ready
    );
    modport sink (
        input  valid, read_data, irq_line, pin_drive,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/gpio_controller_edge_irq_unit.sv =====
// GPIO edge-interrupt controller: responses are valid the cycle after the command beat;
// throughput 1 command per cycle while the response side takes a beat each cycle.
// All state updates and the response are computed in one pass and land in the
// register file and the response register at the same edge.
// rst_n (async, active low) clears the register file, all PWM words and the response valid.
// Depends on gpioei_pkg, gpioei_if and gpio_controller_edge_irq_unit_assert.svh.
`default_nettype none
`include "gpio_controller_edge_irq_unit_assert.svh"

module gpio_controller_edge_irq_unit #(
    parameter int NUM_PINS = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    gpioei_cmd_if.sink    cmd,
    gpioei_rsp_if.source  rsp
);
    import gpioei_pkg::*;

    localparam logic [DATA_W-1:0] PIN_MASK  = 32'hFFFF_FFFF >> (32 - NUM_PINS);
    localparam logic [PIN_W:0]    PIN_LIMIT = (PIN_W + 1)'(NUM_PINS);

    // Register file
    logic [DATA_W-1:0] input_reg,    input_next;
    logic [DATA_W-1:0] oe_reg,       oe_next;
    logic [DATA_W-1:0] irq_mask_reg, irq_mask_next;
    logic [DATA_W-1:0] out_reg,      out_next;
    logic [DATA_W-1:0] debounce_reg, debounce_next;
    logic [DATA_W-1:0] rise_en_reg,  rise_en_next;
    logic [DATA_W-1:0] fall_en_reg,  fall_en_next;
    logic [DATA_W-1:0] rise_pnd_reg, rise_pnd_next;
    logic [DATA_W-1:0] fall_pnd_reg, fall_pnd_next;
    logic [DATA_W-1:0] invert_reg,   invert_next;
    logic [DATA_W-1:0] divider_reg,  divider_next;
    logic [DATA_W-1:0] pwm_tmr_reg,  pwm_tmr_next;
    logic [DATA_W-1:0] pull_en_reg,  pull_en_next;
    logic [DATA_W-1:0] pull_sns_reg, pull_sns_next;
    logic [DATA_W-1:0] pwm_duty_reg   [PWM_ENTRIES];
    logic [DATA_W-1:0] pwm_reload_reg [PWM_ENTRIES];

    // Response register
    logic              rsp_valid_reg;
    logic [DATA_W-1:0] read_data_reg, read_data_next;
    logic              irq_reg,       irq_next;
    logic [DATA_W-1:0] drive_reg,     drive_next;

    // Decode
    logic                 accept;
    logic [WORD_W-1:0]    word;
    logic                 pwm_hit;
    logic [PWM_IDX_W-1:0] pwm_idx;
    logic                 pwm_odd;
    logic                 pwm_we;
    logic                 pwm_rd;
    logic                 rise_any;
    logic                 fall_any;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign word      = cmd.address[ADDR_W-1:2];
    assign pwm_hit   = (cmd.address >= PWM_FIRST) && (cmd.address <= PWM_LAST);
    assign pwm_idx   = cmd.address[PWM_IDX_W+2:3];
    assign pwm_odd   = cmd.address[2];
    assign rise_any  = |(rise_pnd_reg & rise_en_reg);
    assign fall_any  = |(fall_pnd_reg & fall_en_reg);

    // Next state and response for the accepted beat
    always_comb
    begin
        logic [DATA_W-1:0] pin_bit;
        logic [DATA_W-1:0] level_next;
        logic [DATA_W-1:0] edge_bits;
        logic [DATA_W-1:0] seen;

        input_next     = input_reg;
        oe_next        = oe_reg;
        irq_mask_next  = irq_mask_reg;
        out_next       = out_reg;
        debounce_next  = debounce_reg;
        rise_en_next   = rise_en_reg;
        fall_en_next   = fall_en_reg;
        rise_pnd_next  = rise_pnd_reg;
        fall_pnd_next  = fall_pnd_reg;
        invert_next    = invert_reg;
        divider_next   = divider_reg;
        pwm_tmr_next   = pwm_tmr_reg;
        pull_en_next   = pull_en_reg;
        pull_sns_next  = pull_sns_reg;
        read_data_next = '0;
        pwm_we         = 1'b0;
        pwm_rd         = 1'b0;

        pin_bit    = DATA_W'(1) << cmd.pin_index;
        level_next = cmd.pin_level ? (input_reg | pin_bit) : (input_reg & ~pin_bit);
        edge_bits  = input_reg ^ level_next;
        seen       = level_next ^ invert_reg;

        if (accept)
        begin
            case (cmd.operation)
                OP_READ:
                begin
                    case (word)
                        W_INPUT:    read_data_next = input_reg;
                        W_OE:       read_data_next = oe_reg;
                        W_IRQ_MASK: read_data_next = irq_mask_reg;
                        W_PENDING:  read_data_next = rise_pnd_reg | fall_pnd_reg;
                        W_OUT:      read_data_next = out_reg;
                        W_DEBOUNCE: read_data_next = debounce_reg;
                        W_RISE_EN:  read_data_next = rise_en_reg;
                        W_FALL_EN:  read_data_next = fall_en_reg;
                        W_RISE_PND: read_data_next = rise_pnd_reg;
                        W_FALL_PND: read_data_next = fall_pnd_reg;
                        W_STATUS:   read_data_next = (rise_any ? STATUS_RISE : '0)
                                                   | (fall_any ? STATUS_FALL : '0);
                        W_INVERT:   read_data_next = invert_reg;
                        W_DIVIDER:  read_data_next = divider_reg;
                        W_PWM_TMR:  read_data_next = pwm_tmr_reg;
                        W_PULL_EN:  read_data_next = pull_en_reg;
                        W_PULL_SNS: read_data_next = pull_sns_reg;
                        default:    pwm_rd         = pwm_hit;
                    endcase
                end
                OP_WRITE:
                begin
                    case (word)
                        W_OE:       oe_next       = cmd.write_data;
                        W_IRQ_MASK: irq_mask_next = cmd.write_data;
                        W_PENDING:
                        begin
                            rise_pnd_next = rise_pnd_reg & ~cmd.write_data;
                            fall_pnd_next = fall_pnd_reg & ~cmd.write_data;
                        end
                        W_OUT:      out_next      = cmd.write_data;
                        W_OUT_SET:  out_next      = out_reg | cmd.write_data;
                        W_OUT_CLR:  out_next      = out_reg & ~cmd.write_data;
                        W_OE_SET:   oe_next       = oe_reg | cmd.write_data;
                        W_OE_CLR:   oe_next       = oe_reg & ~cmd.write_data;
                        W_DEBOUNCE: debounce_next = cmd.write_data;
                        W_RISE_EN:  rise_en_next  = cmd.write_data;
                        W_FALL_EN:  fall_en_next  = cmd.write_data;
                        W_RISE_PND: rise_pnd_next = rise_pnd_reg & ~cmd.write_data;
                        W_FALL_PND: fall_pnd_next = fall_pnd_reg & ~cmd.write_data;
                        W_INVERT:   invert_next   = cmd.write_data;
                        W_DIVIDER:  divider_next  = cmd.write_data;
                        W_PWM_TMR:  pwm_tmr_next  = cmd.write_data;
                        W_PULL_EN:  pull_en_next  = cmd.write_data;
                        W_PULL_SNS: pull_sns_next = cmd.write_data;
                        default:    pwm_we        = pwm_hit;
                    endcase
                end
                OP_PIN:
                begin
                    // Store the new level first, then flag the edge after inversion
                    if ({1'b0, cmd.pin_index} < PIN_LIMIT)
                    begin
                        rise_pnd_next = rise_pnd_reg | (edge_bits & seen);
                        fall_pnd_next = fall_pnd_reg | (edge_bits & ~seen);
                        input_next    = level_next;
                    end
                end
                default: ;
            endcase
        end

        irq_next   = (|(rise_pnd_next & rise_en_next)) || (|(fall_pnd_next & fall_en_next));
        drive_next = out_next & oe_next & PIN_MASK;
    end

    // Register file update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_reg    <= '0;
            oe_reg       <= '0;
            irq_mask_reg <= '0;
            out_reg      <= '0;
            debounce_reg <= '0;
            rise_en_reg  <= '0;
            fall_en_reg  <= '0;
            rise_pnd_reg <= '0;
            fall_pnd_reg <= '0;
            invert_reg   <= '0;
            divider_reg  <= '0;
            pwm_tmr_reg  <= '0;
            pull_en_reg  <= '0;
            pull_sns_reg <= '0;
        end
        else
        begin
            input_reg    <= input_next;
            oe_reg       <= oe_next;
            irq_mask_reg <= irq_mask_next;
            out_reg      <= out_next;
            debounce_reg <= debounce_next;
            rise_en_reg  <= rise_en_next;
            fall_en_reg  <= fall_en_next;
            rise_pnd_reg <= rise_pnd_next;
            fall_pnd_reg <= fall_pnd_next;
            invert_reg   <= invert_next;
            divider_reg  <= divider_next;
            pwm_tmr_reg  <= pwm_tmr_next;
            pull_en_reg  <= pull_en_next;
            pull_sns_reg <= pull_sns_next;
        end
    end

    // PWM word store: one write port, reads land in the response register below
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PWM_ENTRIES; i++)
            begin
                pwm_duty_reg[i]   <= '0;
                pwm_reload_reg[i] <= '0;
            end
        end
        else if (pwm_we)
        begin
            if (pwm_odd)
            begin
                pwm_reload_reg[pwm_idx] <= cmd.write_data;
            end
            else
            begin
                pwm_duty_reg[pwm_idx] <= cmd.write_data;
            end
        end
    end

    // Response valid: set on accept, drop once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (pwm_rd)
            begin
                read_data_reg <= pwm_odd ? pwm_reload_reg[pwm_idx] : pwm_duty_reg[pwm_idx];
            end
            else
            begin
                read_data_reg <= read_data_next;
            end
            irq_reg   <= irq_next;
            drive_reg <= drive_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = read_data_reg;
    assign rsp.irq_line  = irq_reg;
    assign rsp.pin_drive = drive_reg;

    // Checks
    `GPIOEI_ASSERT(a_irq_matches_state, clk, rst_n,
        $past(accept) |-> (rsp.irq_line == (rise_any || fall_any)),
        "irq_line does not match pending and enable registers")
    `GPIOEI_ASSERT(a_pending_set_by_pin, clk, rst_n,
        (|((rise_pnd_reg & ~$past(rise_pnd_reg)) | (fall_pnd_reg & ~$past(fall_pnd_reg))))
            |-> $past(accept && (cmd.operation == OP_PIN)),
        "event bit set without a pin change")
    `GPIOEI_ASSERT(a_one_level_at_a_time, clk, rst_n,
        $countones(input_reg ^ $past(input_reg)) <= 1,
        "more than one input level changed in one beat")
    `GPIOEI_ASSERT_ALWAYS(a_drive_masked, clk,
        rsp.valid |-> ((rsp.pin_drive & ~PIN_MASK) == '0),
        "pin_drive has bits above the pin count")

endmodule

`default_nettype wire
